// ----- rtl/core/humidity_temp_frame_decoder_defines.svh -----
// ----------------------------------------------------------------------------
// Humidity/temperature frame decoder assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and disabled
// while the synchronous active-low reset is held.
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_TEMP_FRAME_DECODER_DEFINES_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_DEFINES_SVH

// lbl: cond implies prop on the same edge
`define HTFD_ASSERT_IMPLIES(lbl, clk, rstn, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error(msg);

// lbl: cond never holds
`define HTFD_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error(msg);

`endif

// ----- rtl/core/htfd_pkg.sv -----
// ----------------------------------------------------------------------------
// htfd_pkg
// Types, constants and the CRC-8 helper for the humidity/temperature decoder.
// ----------------------------------------------------------------------------
package htfd_pkg;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    localparam int TEMP_SPAN   = 175 * 10;
    localparam int TEMP_OFFSET = 450;
    localparam int HUM_SPAN    = 100;

    localparam int RAW_W    = 16;
    localparam int TPROD_W  = 27;  // 65535 * 1750 fits in 27 bits
    localparam int HPROD_W  = 23;  // 65535 * 100 fits in 23 bits
    localparam int TEMP_W   = 12;
    localparam int HUM_W    = 7;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 24;

    // byte positions within a frame
    localparam logic [2:0] POS_T_MSB = 3'd0;
    localparam logic [2:0] POS_T_LSB = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_MSB = 3'd3;
    localparam logic [2:0] POS_H_LSB = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    typedef struct packed {
        logic             crc_ok;
        logic [RAW_W-1:0] temp_raw;
        logic [RAW_W-1:0] hum_raw;
    } frame_t;

    // CRC-8, MSB first, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/core/htfd_frame.sv -----
// ----------------------------------------------------------------------------
// htfd_frame
// Byte position tracker, running CRC and raw word capture. Emits one frame
// record after the sixth byte.
// ----------------------------------------------------------------------------
module htfd_frame (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  in_start,
    input  logic [7:0]            in_byte,
    output logic                  fr_valid,
    input  logic                  fr_ready,
    output htfd_pkg::frame_t      fr_data
);
    import htfd_pkg::*;

    logic [2:0]       pos_reg, pos_next;
    logic [7:0]       crc_reg, crc_next;
    logic [RAW_W-1:0] temp_raw_reg, temp_raw_next;
    logic [RAW_W-1:0] hum_raw_reg, hum_raw_next;
    logic             tgood_reg, tgood_next;
    logic             fr_valid_reg, fr_valid_next;
    frame_t           fr_reg, fr_next;

    logic             take;
    logic             restart;
    logic [2:0]       pos_eff;
    logic [7:0]       crc_eff;
    logic [7:0]       crc_upd;

    assign in_ready = !fr_valid_reg || fr_ready;
    assign take     = in_valid && in_ready;
    assign restart  = in_start || (pos_reg > POS_H_CRC);
    assign pos_eff  = restart ? POS_T_MSB : pos_reg;
    assign crc_eff  = restart ? CRC_INIT : crc_reg;
    assign crc_upd  = crc8_byte(crc_eff, in_byte);

    always_comb begin
        pos_next      = pos_reg;
        crc_next      = crc_reg;
        temp_raw_next = temp_raw_reg;
        hum_raw_next  = hum_raw_reg;
        tgood_next    = tgood_reg;
        fr_valid_next = fr_valid_reg && !fr_ready;
        fr_next       = fr_reg;
        if (take) begin
            pos_next = pos_eff + 3'd1;
            case (pos_eff)
                POS_T_MSB: begin
                    temp_raw_next = {in_byte, temp_raw_reg[7:0]};
                    crc_next      = crc_upd;
                end
                POS_T_LSB: begin
                    temp_raw_next = {temp_raw_reg[15:8], in_byte};
                    crc_next      = crc_upd;
                end
                POS_T_CRC: begin
                    tgood_next = (crc_eff == in_byte);
                    crc_next   = CRC_INIT;
                end
                POS_H_MSB: begin
                    hum_raw_next = {in_byte, hum_raw_reg[7:0]};
                    crc_next     = crc_upd;
                end
                POS_H_LSB: begin
                    hum_raw_next = {hum_raw_reg[15:8], in_byte};
                    crc_next     = crc_upd;
                end
                default: begin
                    fr_valid_next   = 1'b1;
                    fr_next.crc_ok  = tgood_reg && (crc_eff == in_byte);
                    fr_next.temp_raw = temp_raw_reg;
                    fr_next.hum_raw  = hum_raw_reg;
                    pos_next        = POS_T_MSB;
                    crc_next        = CRC_INIT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= POS_T_MSB;
            crc_reg      <= CRC_INIT;
            tgood_reg    <= 1'b0;
            fr_valid_reg <= 1'b0;
        end else begin
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            tgood_reg    <= tgood_next;
            fr_valid_reg <= fr_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        temp_raw_reg <= temp_raw_next;
        hum_raw_reg  <= hum_raw_next;
        fr_reg       <= fr_next;
    end

    assign fr_valid = fr_valid_reg;
    assign fr_data  = fr_reg;

endmodule

// ----- rtl/core/htfd_conv.sv -----
// ----------------------------------------------------------------------------
// htfd_conv
// Two-stage conversion: scale multiply, then divide by 65535 and offset,
// into the output register.
// ----------------------------------------------------------------------------
module htfd_conv (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          fr_valid,
    output logic                          fr_ready,
    input  htfd_pkg::frame_t              fr_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_ok,
    output logic [htfd_pkg::TEMP_W-1:0]   out_temp,
    output logic [htfd_pkg::HUM_W-1:0]    out_hum
);
    import htfd_pkg::*;

    localparam logic [10:0] TSPAN_C = 11'(TEMP_SPAN);
    localparam logic [6:0]  HSPAN_C = 7'(HUM_SPAN);
    localparam logic [TEMP_W-1:0] TOFF_C = TEMP_W'(TEMP_OFFSET);

    logic               a_valid_reg, a_valid_next;
    logic               a_ok_reg;
    logic [TPROD_W-1:0] t_prod_reg;
    logic [HPROD_W-1:0] h_prod_reg;

    logic               o_valid_reg, o_valid_next;
    logic               o_ok_reg;
    logic [TEMP_W-1:0]  o_temp_reg, o_temp_next;
    logic [HUM_W-1:0]   o_hum_reg, o_hum_next;

    logic               b_ready;
    logic               a_load;
    logic               b_load;
    logic [TPROD_W:0]   t_sum;
    logic [HPROD_W:0]   h_sum;

    assign b_ready  = !o_valid_reg || out_ready;
    assign fr_ready = !a_valid_reg || b_ready;
    assign a_load   = fr_valid && fr_ready;
    assign b_load   = a_valid_reg && b_ready;

    assign a_valid_next = a_load || (a_valid_reg && !b_ready);
    assign o_valid_next = b_load || (o_valid_reg && !out_ready);

    // x / 65535 == (x + (x >> 16) + 1) >> 16 for the ranges here
    assign t_sum = {1'b0, t_prod_reg} + (TPROD_W+1)'(t_prod_reg >> 16)
                   + (TPROD_W+1)'(1);
    assign h_sum = {1'b0, h_prod_reg} + (HPROD_W+1)'(h_prod_reg >> 16)
                   + (HPROD_W+1)'(1);

    always_comb begin
        o_temp_next = '0;
        o_hum_next  = '0;
        if (a_ok_reg) begin
            o_temp_next = {1'b0, t_sum[26:16]} - TOFF_C;
            o_hum_next  = h_sum[22:16];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_load) begin
            a_ok_reg   <= fr_data.crc_ok;
            t_prod_reg <= TPROD_W'(fr_data.temp_raw) * TPROD_W'(TSPAN_C);
            h_prod_reg <= HPROD_W'(fr_data.hum_raw) * HPROD_W'(HSPAN_C);
        end
        if (b_load) begin
            o_ok_reg   <= a_ok_reg;
            o_temp_reg <= o_temp_next;
            o_hum_reg  <= o_hum_next;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_ok    = o_ok_reg;
    assign out_temp  = o_temp_reg;
    assign out_hum   = o_hum_reg;

endmodule

// ----- rtl/core/humidity_temp_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder
// Checks the two CRC-8 protected words of a six-byte sensor frame and
// converts them to tenths of a degree and whole percent humidity.
// ----------------------------------------------------------------------------
// channel  | direction | tdata                            | tuser
// s_       | in        | [7:0] data_byte                  | frame_start
// m_       | out       | [11:0] temp tenths, [18:12] hum  | crc_ok
//
// One byte word is taken every cycle while s_tready is high. After the sixth
// byte a result passes the frame, multiply and output registers in turn.
// Reset clears position, CRC and all valid flags; the raw words hold garbage
// until a frame writes them. An m_ stall backs up through the result stages
// and, once they are full, drops s_tready for every byte, closing or not.
// ----------------------------------------------------------------------------
`include "humidity_temp_frame_decoder_defines.svh"

module humidity_temp_frame_decoder (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [htfd_pkg::S_DATA_W-1:0]  s_tdata,   // [7:0] data_byte
    input  logic                           s_tuser,   // frame_start
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [htfd_pkg::M_DATA_W-1:0]  m_tdata,   // [11:0] temperature_tenths,
                                                      // [18:12] humidity_percent
    output logic                           m_tuser    // crc_ok
);
    import htfd_pkg::*;

    logic              fr_valid;
    logic              fr_ready;
    frame_t            fr_data;
    logic [TEMP_W-1:0] temp;
    logic [HUM_W-1:0]  hum;

    htfd_frame u_frame (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_start (s_tuser),
        .in_byte  (s_tdata),
        .fr_valid (fr_valid),
        .fr_ready (fr_ready),
        .fr_data  (fr_data)
    );

    htfd_conv u_conv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fr_valid  (fr_valid),
        .fr_ready  (fr_ready),
        .fr_data   (fr_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_ok    (m_tuser),
        .out_temp  (temp),
        .out_hum   (hum)
    );

    assign m_tdata = {(M_DATA_W-TEMP_W-HUM_W)'(0), hum, temp};

    `HTFD_ASSERT_IMPLIES(a_bad_crc_zero, aclk, aresetn, m_tvalid && !m_tuser, m_tdata == '0, "bad-CRC word carries nonzero values")
    `HTFD_ASSERT_IMPLIES(a_hum_range, aclk, aresetn, m_tvalid, m_tdata[18:12] <= 7'd100, "humidity above 100 percent")
    `HTFD_ASSERT_NEVER(a_temp_range, aclk, aresetn, m_tvalid && m_tuser && ($signed(m_tdata[11:0]) < -12'sd450 || $signed(m_tdata[11:0]) > 12'sd1300), "temperature out of range")

endmodule
